FILE: hdl/lcw_pkg.sv
package lcw_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int BIT_CNT_W   = $clog2(SAMPLE_BITS + 1);

   localparam int SUM_W    = 32;
   localparam int CNT_W    = 8;
   localparam int OFFSET_W = 24;
   localparam int SCALE_W  = 16;
   localparam int WEIGHT_W = 16;
   localparam int RAW_W    = 24;

   // shared restoring divider
   localparam int DIV_W     = SUM_W;
   localparam int DIVR_W    = SCALE_W;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = OFFSET_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_OFFSET   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_DIVISOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGE_COUNT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_LIMIT  = 2'd3;

   localparam logic [OFFSET_W-1:0] ZERO_OFFSET_RST   = 24'd8543544;
   localparam logic [SCALE_W-1:0]  SCALE_DIVISOR_RST = 16'd437;
   localparam logic [CNT_W-1:0]    AVERAGE_COUNT_RST = 8'd1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_LIMIT_RST  = 16'd5000;

   // what the sampler reports for the tick being transferred
   typedef struct packed {
      logic              clock_level;
      logic              complete;
      logic [SUM_W-1:0]  sum;
      logic [CNT_W-1:0]  count;
   } lcw_sample_type;

endpackage

FILE: hdl/lcw_divider.sv
module lcw_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lcw_pkg::DIV_W-1:0]  dividend,
   input  logic [lcw_pkg::DIVR_W-1:0] divisor,
   output logic                       done,
   output logic [lcw_pkg::DIV_W-1:0]  quotient
);
   import lcw_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [DIVR_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVR_W-1:0]    divisor_ff, divisor_in;

   logic [DIVR_W:0] rem_shift;
   logic            fits;

   // one quotient bit per cycle, MSB first
   always_comb begin
      rem_shift  = {rem_ff, quo_ff[DIV_W-1]};
      fits       = rem_shift >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? DIVR_W'(rem_shift - {1'b0, divisor_ff}) : rem_shift[DIVR_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hdl/lcw_sampler.sv
module lcw_sampler (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      data_level,
   input  logic [lcw_pkg::CNT_W-1:0] average_count,
   output lcw_pkg::lcw_sample_type   sample
);
   import lcw_pkg::*;

   typedef enum logic [4:0] {
      PH_WAIT     = 5'b00001,
      PH_BIT_HIGH = 5'b00010,
      PH_BIT_LOW  = 5'b00100,
      PH_END_HIGH = 5'b01000,
      PH_END_LOW  = 5'b10000
   } lcw_phase_type;

   localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   lcw_phase_type          phase_ff, phase_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [SAMPLE_BITS-1:0] shift_ff, shift_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       taken_ff, taken_in;

   logic [BIT_CNT_W-1:0] bit_cnt_inc;
   logic [CNT_W-1:0]     taken_inc;
   logic [CNT_W-1:0]     count_eff;
   logic [SUM_W-1:0]     sum_add;

   always_comb begin
      count_eff   = (average_count == '0) ? CNT_W'(1) : average_count;
      sum_add     = sum_ff + SUM_W'(shift_ff ^ SIGN_FLIP);
      bit_cnt_inc = bit_cnt_ff + 1'b1;
      taken_inc   = taken_ff + 1'b1;

      phase_in   = phase_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      sum_in     = sum_ff;
      taken_in   = taken_ff;

      sample.clock_level = 1'b0;
      sample.complete    = 1'b0;
      sample.sum         = sum_add;
      sample.count       = count_eff;

      case (phase_ff)
         PH_BIT_HIGH: begin
            sample.clock_level = 1'b1;
            phase_in = PH_BIT_LOW;
         end
         PH_BIT_LOW: begin
            shift_in   = {shift_ff[SAMPLE_BITS-2:0], data_level};
            bit_cnt_in = bit_cnt_inc;
            phase_in   = (bit_cnt_inc >= BIT_CNT_W'(SAMPLE_BITS)) ? PH_END_HIGH : PH_BIT_HIGH;
         end
         PH_END_HIGH: begin
            sample.clock_level = 1'b1;
            phase_in = PH_END_LOW;
         end
         PH_END_LOW: begin
            if (taken_inc >= count_eff) begin
               sample.complete = 1'b1;
               sum_in   = '0;
               taken_in = '0;
            end else begin
               sum_in   = sum_add;
               taken_in = taken_inc;
            end
            shift_in   = '0;
            bit_cnt_in = '0;
            phase_in   = PH_WAIT;
         end
         default: begin
            // also catches stray phase codes
            phase_in = PH_WAIT;
            if (!data_level) begin
               bit_cnt_in = '0;
               shift_in   = '0;
               phase_in   = PH_BIT_HIGH;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAIT;
         bit_cnt_ff <= '0;
         shift_ff   <= '0;
         sum_ff     <= '0;
         taken_ff   <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         bit_cnt_ff <= bit_cnt_in;
         shift_ff   <= shift_in;
         sum_ff     <= sum_in;
         taken_ff   <= taken_in;
      end
   end

endmodule

FILE: hdl/load_cell_serial_reader_weigher.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  req_data_level
// rsp      out        rsp_valid / rsp_stall  rsp_clock_level, rsp_weight_valid,
//                                            rsp_weight, rsp_raw_average
// csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// A tick that completes no average has its result registered; it shows on rsp the
// next cycle. A tick that completes an average passes ST_DIV_AVG, ST_DIV_WT (skipped
// when the difference is not positive or the scale is zero) and ST_OUT: the
// bit-serial divider runs 32 steps for the average and, only when a weight can
// result, 32 more for the weight. Reset is synchronous and clears all control state.
// req_stall is high outside ST_IDLE or while a result is held by rsp_stall.
module load_cell_serial_reader_weigher (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_data_level,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_clock_level,
   output logic                           rsp_weight_valid,
   output logic [lcw_pkg::WEIGHT_W-1:0]   rsp_weight,
   output logic [lcw_pkg::RAW_W-1:0]      rsp_raw_average,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lcw_pkg::CSR_DATA_W-1:0] csr_data
);
   import lcw_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_DIV_AVG = 4'b0010,
      ST_DIV_WT  = 4'b0100,
      ST_OUT     = 4'b1000
   } lcw_state_type;

   lcw_state_type state_ff, state_in;

   logic [OFFSET_W-1:0] zero_offset_ff;
   logic [SCALE_W-1:0]  scale_ff;
   logic [CNT_W-1:0]    avg_count_ff;
   logic [WEIGHT_W-1:0] limit_ff;

   logic [RAW_W-1:0]    raw_ff, raw_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_clock_ff, rsp_clock_in;
   logic                rsp_wvalid_ff, rsp_wvalid_in;
   logic [WEIGHT_W-1:0] rsp_weight_ff, rsp_weight_in;
   logic [RAW_W-1:0]    rsp_raw_ff, rsp_raw_in;

   logic           out_free;
   logic           req_take;
   lcw_sample_type sample;

   logic              div_start;
   logic [DIV_W-1:0]  div_dividend;
   logic [DIVR_W-1:0] div_divisor;
   logic              div_done;
   logic [DIV_W-1:0]  div_quotient;

   logic [DIV_W:0]    diff;
   logic              q_high;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   lcw_sampler u_sampler (
      .clock         (clock),
      .reset         (reset),
      .step          (req_take),
      .data_level    (req_data_level),
      .average_count (avg_count_ff),
      .sample        (sample)
   );

   lcw_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      diff   = {1'b0, div_quotient} - (DIV_W + 1)'(zero_offset_ff);
      q_high = |div_quotient[DIV_W-1:WEIGHT_W];

      state_in     = state_ff;
      raw_in       = raw_ff;
      weight_in    = weight_ff;
      div_start    = 1'b0;
      div_dividend = sample.sum;
      div_divisor  = DIVR_W'(sample.count);

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_clock_in  = rsp_clock_ff;
      rsp_wvalid_in = rsp_wvalid_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_raw_in    = rsp_raw_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (sample.complete) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV_AVG;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_clock_in  = sample.clock_level;
                  rsp_wvalid_in = 1'b0;
                  rsp_weight_in = '0;
                  rsp_raw_in    = '0;
               end
            end
         end
         ST_DIV_AVG: begin
            if (div_done) begin
               raw_in = div_quotient[RAW_W-1:0];
               // non-positive difference or zero scale cannot give a weight
               if (diff[DIV_W] || (diff == '0) || (scale_ff == '0)) begin
                  weight_in = '0;
                  state_in  = ST_OUT;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = diff[DIV_W-1:0];
                  div_divisor  = scale_ff;
                  state_in     = ST_DIV_WT;
               end
            end
         end
         ST_DIV_WT: begin
            if (div_done) begin
               if (q_high || (div_quotient[WEIGHT_W-1:0] >= limit_ff) ||
                   (div_quotient[WEIGHT_W-1:0] == '0)) begin
                  weight_in = '0;
               end else begin
                  weight_in = div_quotient[WEIGHT_W-1:0];
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_clock_in  = 1'b0;
               rsp_wvalid_in = 1'b1;
               rsp_weight_in = weight_ff;
               rsp_raw_in    = raw_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff        <= raw_in;
      weight_ff     <= weight_in;
      rsp_clock_ff  <= rsp_clock_in;
      rsp_wvalid_ff <= rsp_wvalid_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_raw_ff    <= rsp_raw_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff <= ZERO_OFFSET_RST;
         scale_ff       <= SCALE_DIVISOR_RST;
         avg_count_ff   <= AVERAGE_COUNT_RST;
         limit_ff       <= WEIGHT_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ZERO_OFFSET:   zero_offset_ff <= csr_data[OFFSET_W-1:0];
            CSR_SCALE_DIVISOR: scale_ff       <= csr_data[SCALE_W-1:0];
            CSR_AVERAGE_COUNT: avg_count_ff   <= csr_data[CNT_W-1:0];
            CSR_WEIGHT_LIMIT:  limit_ff       <= csr_data[WEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_clock_level  = rsp_clock_ff;
   assign rsp_weight_valid = rsp_wvalid_ff;
   assign rsp_weight       = rsp_weight_ff;
   assign rsp_raw_average  = rsp_raw_ff;

endmodule

FILE: tb/lcw_checker.sv
module lcw_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_data_level,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_clock_level,
   input  logic                           rsp_weight_valid,
   input  logic [lcw_pkg::WEIGHT_W-1:0]   rsp_weight,
   input  logic [lcw_pkg::RAW_W-1:0]      rsp_raw_average,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [lcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lcw_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             mismatches,
   output int                             pending_ticks
);
   timeunit 1ns;
   timeprecision 1ps;

   import lcw_pkg::*;

   typedef enum logic [4:0] {
      WAIT_START = 5'b00001,
      BIT_HIGH   = 5'b00010,
      BIT_LOW    = 5'b00100,
      END_HIGH   = 5'b01000,
      END_LOW    = 5'b10000
   } conv_phase_type;

   typedef struct packed {
      logic                clock_level;
      logic                weight_valid;
      logic [WEIGHT_W-1:0] weight;
      logic [RAW_W-1:0]    raw_average;
   } tick_result_type;

   // shadow of the block's registers
   logic [OFFSET_W-1:0] tare_raw;
   logic [SCALE_W-1:0]  counts_per_unit;
   logic [CNT_W-1:0]    words_per_result;
   logic [WEIGHT_W-1:0] weight_ceiling;

   // shadow of the conversion state
   conv_phase_type         phase;
   logic [BIT_CNT_W-1:0]   bits_in;
   logic [SAMPLE_BITS-1:0] shift_word;
   logic [SUM_W-1:0]       raw_sum;
   logic [CNT_W-1:0]       words_summed;

   tick_result_type expected_ticks[$];
   tick_result_type oldest;

   function automatic tick_result_type weigh_tick(input logic data);
      tick_result_type  r;
      logic [CNT_W-1:0] divisor;
      logic [SUM_W-1:0] avg;
      longint           diff;
      longint           q;
      r = '0;
      divisor = (words_per_result == '0) ? CNT_W'(1) : words_per_result;
      case (phase)
         BIT_HIGH: begin
            r.clock_level = 1'b1;
            phase = BIT_LOW;
         end
         BIT_LOW: begin
            shift_word = {shift_word[SAMPLE_BITS-2:0], data};
            bits_in = bits_in + 1'b1;
            phase = (bits_in >= SAMPLE_BITS) ? END_HIGH : BIT_HIGH;
         end
         END_HIGH: begin
            r.clock_level = 1'b1;
            phase = END_LOW;
         end
         END_LOW: begin
            // flipping the top bit turns two's complement into offset binary
            raw_sum = raw_sum + SUM_W'(shift_word ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}});
            words_summed = words_summed + 1'b1;
            if (words_summed >= divisor) begin
               avg = raw_sum / SUM_W'(divisor);
               diff = $signed({32'd0, avg}) - $signed({40'd0, tare_raw});
               q = 0;
               if (counts_per_unit != '0)
                  q = diff / $signed({48'd0, counts_per_unit});
               if (q >= $signed({48'd0, weight_ceiling}) || q <= 0)
                  q = 0;
               r.weight_valid = 1'b1;
               r.weight = q[WEIGHT_W-1:0];
               r.raw_average = avg[RAW_W-1:0];
               raw_sum = '0;
               words_summed = '0;
            end
            shift_word = '0;
            bits_in = '0;
            phase = WAIT_START;
         end
         default: begin
            phase = WAIT_START;
            if (!data) begin
               bits_in = '0;
               shift_word = '0;
               phase = BIT_HIGH;
            end
         end
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tare_raw = ZERO_OFFSET_RST;
         counts_per_unit = SCALE_DIVISOR_RST;
         words_per_result = AVERAGE_COUNT_RST;
         weight_ceiling = WEIGHT_LIMIT_RST;
         phase = WAIT_START;
         bits_in = '0;
         shift_word = '0;
         raw_sum = '0;
         words_summed = '0;
         expected_ticks.delete();
         mismatches = 0;
         pending_ticks <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_ticks.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual clk %b valid %b weight %0h raw %0h",
                        $time, rsp_clock_level, rsp_weight_valid, rsp_weight, rsp_raw_average);
               mismatches++;
            end else begin
               oldest = expected_ticks.pop_front();
               check_field("clock_level", 32'(oldest.clock_level), 32'(rsp_clock_level));
               check_field("weight_valid", 32'(oldest.weight_valid), 32'(rsp_weight_valid));
               check_field("weight", 32'(oldest.weight), 32'(rsp_weight));
               check_field("raw_average", 32'(oldest.raw_average), 32'(rsp_raw_average));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ZERO_OFFSET:   tare_raw = csr_data[OFFSET_W-1:0];
               CSR_SCALE_DIVISOR: counts_per_unit = csr_data[SCALE_W-1:0];
               CSR_AVERAGE_COUNT: words_per_result = csr_data[CNT_W-1:0];
               CSR_WEIGHT_LIMIT:  weight_ceiling = csr_data[WEIGHT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_ticks.push_back(weigh_tick(req_data_level));
         pending_ticks <= expected_ticks.size();
      end
   end

endmodule

FILE: tb/load_cell_serial_reader_weigher_tb.sv
module load_cell_serial_reader_weigher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lcw_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_data_level = 1'b1;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_clock_level;
   logic                  rsp_weight_valid;
   logic [WEIGHT_W-1:0]   rsp_weight;
   logic [RAW_W-1:0]      rsp_raw_average;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int mismatches;
   int pending_ticks;
   int cycle_count = 0;

   // settings in force, used only to aim the raw words at useful ranges
   logic [OFFSET_W-1:0] cfg_offset = ZERO_OFFSET_RST;
   logic [SCALE_W-1:0]  cfg_scale = SCALE_DIVISOR_RST;
   logic [WEIGHT_W-1:0] cfg_limit = WEIGHT_LIMIT_RST;

   int          burst_left = 0;
   bit          steady_send = 1'b0;
   int unsigned stall_mode = 0;
   int unsigned stall_phase = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   load_cell_serial_reader_weigher dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_level   (req_data_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_clock_level  (rsp_clock_level),
      .rsp_weight_valid (rsp_weight_valid),
      .rsp_weight       (rsp_weight),
      .rsp_raw_average  (rsp_raw_average),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   lcw_checker weigh_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_level   (req_data_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_clock_level  (rsp_clock_level),
      .rsp_weight_valid (rsp_weight_valid),
      .rsp_weight       (rsp_weight),
      .rsp_raw_average  (rsp_raw_average),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatches       (mismatches),
      .pending_ticks    (pending_ticks)
   );

   // receiver: stall_mode is redrawn at random, periodically from stall_phase; mode 0 never stalls
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 300 == 299)
         stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ((stall_phase % 5) >= 3);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[load_cell_serial_reader_weigher] ERROR");
         $finish;
      end
   end

   task automatic send_tick(input logic level);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (!steady_send) begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data_level <= level;
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   // one conversion: optional not-ready ticks, start, 24 bit pulses MSB first,
   // then the extra pulse; data on high ticks is don't-care
   task automatic send_word(input logic [SAMPLE_BITS-1:0] raw);
      logic [SAMPLE_BITS-1:0] code;
      int                     waits;
      code = raw ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      waits = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      repeat (waits) send_tick(1'b1);
      send_tick(1'b0);
      for (int i = SAMPLE_BITS - 1; i >= 0; i--) begin
         send_tick(1'($urandom_range(0, 1)));
         send_tick(code[i]);
      end
      send_tick(1'($urandom_range(0, 1)));
      send_tick(1'($urandom_range(0, 1)));
   endtask

   // random ticks, then enough high ticks to finish any word in progress
   task automatic send_noise(input int n);
      repeat (n) send_tick(1'($urandom_range(0, 1)));
      repeat (2 * SAMPLE_BITS + 4) send_tick(1'b1);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_raw();
      longint      v;
      longint      span;
      int unsigned sel;
      sel = $urandom_range(0, 9);
      span = longint'(cfg_scale) * longint'(cfg_limit);
      if (sel < 6)
         v = longint'(cfg_offset) + span * longint'($urandom_range(0, 1100)) / 1000
             - longint'($urandom_range(0, cfg_scale));
      else if (sel < 8)
         v = longint'($urandom_range(0, 24'hFFFFFF));
      else if (sel == 8)
         v = longint'(cfg_offset) + longint'($urandom_range(0, 8)) - 4;
      else
         v = $urandom_range(0, 1) ? 24'hFFFFFF : 0;
      if (v < 0)
         v = 0;
      if (v > 24'hFFFFFF)
         v = 24'hFFFFFF;
      return v[SAMPLE_BITS-1:0];
   endfunction

   task automatic run_words(input int n);
      repeat (n) send_word(pick_raw());
   endtask

   // stop sending and wait until every tick has come back
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_ticks != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // bits above the register width carry junk now and then
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value,
                            input int width);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom_range(0, 1) ? CSR_DATA_W'($urandom) : '0;
      for (int b = 0; b < width; b++)
         word[b] = value[b];
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= word;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting(input logic [OFFSET_W-1:0] offset, input logic [SCALE_W-1:0] scale,
                                input logic [CNT_W-1:0] count, input logic [WEIGHT_W-1:0] limit);
      write_reg(CSR_ZERO_OFFSET, offset, OFFSET_W);
      write_reg(CSR_SCALE_DIVISOR, scale, SCALE_W);
      write_reg(CSR_AVERAGE_COUNT, count, CNT_W);
      write_reg(CSR_WEIGHT_LIMIT, limit, WEIGHT_W);
      csr_valid <= 1'b0;
      cfg_offset = offset;
      cfg_scale = scale;
      cfg_limit = limit;
      steady_send = ($urandom_range(0, 3) == 0);
   endtask

   initial begin
      int count;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: range edges of the weight and the raw word
      send_word('0);
      send_word(24'hFFFFFF);
      send_word(ZERO_OFFSET_RST);
      send_word(24'(ZERO_OFFSET_RST - 1));
      send_word(24'(ZERO_OFFSET_RST + 436));
      send_word(24'(ZERO_OFFSET_RST + 437));
      send_word(24'(ZERO_OFFSET_RST + 437 * 4999 + 436));
      send_word(24'(ZERO_OFFSET_RST + 437 * 5000));
      send_noise(12);
      drain();

      apply_setting('0, 16'd1, 8'd1, 16'hFFFF);
      run_words(2);
      drain();
      apply_setting(24'hFFFFFF, 16'hFFFF, 8'd3, 16'd0);
      run_words(3);
      drain();
      apply_setting(24'd8000000, 16'd0, 8'd2, 16'd1);
      run_words(2);
      drain();
      // a zero count behaves as one
      apply_setting(24'h800000, 16'hFFFF, 8'd0, 16'd255);
      run_words(2);
      drain();
      // largest count, left part way: the partial sum carries into the next setting
      apply_setting(24'h7FFFFF, 16'd100, 8'd255, 16'hFFFF);
      run_words(2);
      drain();

      for (int p = 0; p < 3; p++) begin
         count = $urandom_range(1, 2);
         apply_setting(OFFSET_W'($urandom_range(24'h600000, 24'hA00000)),
                       SCALE_W'($urandom_range(1, 3000)), CNT_W'(count),
                       WEIGHT_W'($urandom_range(1, 65535)));
         run_words(count);
         if (p == 0)
            drain();
         if ($urandom_range(0, 1))
            send_noise($urandom_range(5, 20));
         run_words(count);
         drain();
      end

      apply_setting(ZERO_OFFSET_RST, SCALE_DIVISOR_RST, 8'd2, WEIGHT_LIMIT_RST);
      run_words(2);
      drain();

      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("[load_cell_serial_reader_weigher] OK");
      else
         $display("[load_cell_serial_reader_weigher] ERROR");
      $finish;
   end

endmodule

FILE: files.f
hdl/lcw_pkg.sv
hdl/lcw_divider.sv
hdl/lcw_sampler.sv
hdl/load_cell_serial_reader_weigher.sv
tb/lcw_checker.sv
tb/load_cell_serial_reader_weigher_tb.sv
